@@ hdl/plb_pkg.sv @@
// ----------------------------------------------------------------------------
// plb_pkg: shared types for the price level book
// Level record, broadcast update command and per-chain status.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;

  // One price level held by a cell
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  // Update command broadcast to every cell of one side during apply
  typedef struct packed {
    logic               apply;
    logic               remove;
    logic               any_match;
    logic               full;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cmd_t;

  // Side status seen by the top level
  typedef struct packed {
    logic any_match;
    logic full;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/plb_cell.sv @@
// ----------------------------------------------------------------------------
// plb_cell: one slot of a sorted price level chain
// Compares its level with the broadcast key, then keeps, replaces, takes the
// new level, or takes a neighbor's level to open or close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_cell
  import plb_pkg::*;
#(
  parameter bit BETTER_HIGH = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmp_en,
  input  wire logic [PRICE_W-1:0] cmp_key,
  input  wire cmd_t               cmd,
  input  wire level_t             left_lvl,
  input  wire logic               left_gt,
  input  wire level_t             right_lvl,
  output level_t                  lvl,
  output logic                    gt,
  output logic                    eq
);

  level_t lvl_next;
  logic   gt_next;
  logic   eq_next;
  logic   ahead;

  // Strictly better than the key in this side's order
  assign ahead = BETTER_HIGH ? (lvl.price > cmp_key) : (lvl.price < cmp_key);

  always_comb begin
    gt_next = gt;
    eq_next = eq;
    if (cmp_en) begin
      gt_next = lvl.valid && ahead;
      eq_next = lvl.valid && (lvl.price == cmp_key);
    end
  end

  always_comb begin
    lvl_next = lvl;
    if (cmd.apply) begin
      if (!cmd.remove && cmd.any_match) begin
        // replace the quantity of the existing level
        if (eq) begin
          lvl_next.qty = cmd.qty;
        end
      end else if (!cmd.remove && !cmd.full) begin
        // new price: open a gap at the first slot not ahead of the key
        if (!gt) begin
          if (left_gt) begin
            lvl_next.valid = 1'b1;
            lvl_next.price = cmd.price;
            lvl_next.qty   = cmd.qty;
          end else begin
            lvl_next = left_lvl;
          end
        end
      end else if (cmd.remove && cmd.any_match) begin
        // close the gap from the matched slot onward
        if (!gt) begin
          lvl_next = right_lvl;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl.valid <= 1'b0;
    end else begin
      lvl.valid <= lvl_next.valid;
    end
    lvl.price <= lvl_next.price;
    lvl.qty   <= lvl_next.qty;
    gt        <= gt_next;
    eq        <= eq_next;
  end

endmodule

`default_nettype wire

@@ hdl/plb_chain.sv @@
// ----------------------------------------------------------------------------
// plb_chain: sorted row of price level cells for one book side
// Best level sits in cell 0; valid levels stay packed at the front.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_chain
  import plb_pkg::*;
#(
  parameter int LEVELS      = 64,
  parameter bit BETTER_HIGH = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmp_en,
  input  wire logic [PRICE_W-1:0] cmp_key,
  input  wire logic               apply,
  input  wire logic               remove,
  input  wire logic [PRICE_W-1:0] price,
  input  wire logic [QTY_W-1:0]   qty,
  output level_t                  head,
  output status_t                 status
);

  level_t             lvls [LEVELS];
  logic [LEVELS-1:0]  gts;
  logic [LEVELS-1:0]  eqs;
  cmd_t               cmd;
  level_t             empty_lvl;

  assign empty_lvl = '0;

  assign status.any_match = |eqs;
  assign status.full      = lvls[LEVELS-1].valid;

  assign cmd.apply     = apply;
  assign cmd.remove    = remove;
  assign cmd.any_match = status.any_match;
  assign cmd.full      = status.full;
  assign cmd.price     = price;
  assign cmd.qty       = qty;

  assign head = lvls[0];

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    level_t left_lvl;
    level_t right_lvl;
    logic   left_gt;

    if (i == 0) begin : g_first
      assign left_lvl = empty_lvl;
      assign left_gt  = 1'b1;
    end else begin : g_mid
      assign left_lvl = lvls[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign right_lvl = empty_lvl;
    end else begin : g_inner
      assign right_lvl = lvls[i+1];
    end

    plb_cell #(
      .BETTER_HIGH(BETTER_HIGH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmp_en   (cmp_en),
      .cmp_key  (cmp_key),
      .cmd      (cmd),
      .left_lvl (left_lvl),
      .left_gt  (left_gt),
      .right_lvl(right_lvl),
      .lvl      (lvls[i]),
      .gt       (gts[i]),
      .eq       (eqs[i])
    );
  end

endmodule

`default_nettype wire

@@ hdl/price_level_book_top.sv @@
// ----------------------------------------------------------------------------
// price_level_book_top: top-of-book tracker over bid and ask level chains
// Flow: each update is compared in the cell chain of the addressed side, then
//   applied there; its result waits as pending and moves to the output register.
//   A new update is taken only once the last is applied and its result moves out.
// Reset: synchronous, clears all level valid bits, the sequencer and the
//   output valid flag; both sides start empty.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_book_top
  import plb_pkg::*;
#(
  parameter int LEVELS_PER_SIDE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                side,
  input  wire logic [PRICE_W-1:0]  price_ticks,
  input  wire logic signed [31:0]  quantity,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     bid_valid,
  output logic [PRICE_W-1:0]       best_bid_price,
  output logic [QTY_W-1:0]         best_bid_qty,
  output logic                     ask_valid,
  output logic [PRICE_W-1:0]       best_ask_price,
  output logic [QTY_W-1:0]         best_ask_qty,
  output logic                     dropped
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  logic               state;
  logic               state_next;

  // Latched update command
  logic               cmd_side;
  logic               cmd_remove;
  logic [PRICE_W-1:0] cmd_price;
  logic [QTY_W-1:0]   cmd_qty;

  // Result computed in apply, waiting for the output register
  logic               pending;
  logic               pend_dropped;

  logic               in_xfer;
  logic               load_out;
  logic               in_remove;

  level_t             bid_head;
  level_t             ask_head;
  status_t            bid_status;
  status_t            ask_status;
  status_t            side_status;
  logic               apply_bid;
  logic               apply_ask;

  // Nonpositive quantity deletes the level
  assign in_remove = quantity[31] || (quantity == 32'sd0);

  // Move the waiting result into the output register when the slot frees
  assign load_out = pending && (!out_valid || out_ready);

  // Accept only between items; a waiting result must move out this cycle
  assign in_ready = (state == ST_IDLE) && (!pending || load_out);
  assign in_xfer  = in_valid && in_ready;

  assign apply_bid = (state == ST_APPLY) && (cmd_side == SIDE_BID);
  assign apply_ask = (state == ST_APPLY) && (cmd_side == SIDE_ASK);

  assign side_status = (cmd_side == SIDE_BID) ? bid_status : ask_status;

  // Bid chain: highest price at the head
  plb_chain #(
    .LEVELS     (LEVELS_PER_SIDE),
    .BETTER_HIGH(1'b1)
  ) u_bid_chain (
    .clk    (clk),
    .rst    (rst),
    .cmp_en (in_xfer && (side == SIDE_BID)),
    .cmp_key(price_ticks),
    .apply  (apply_bid),
    .remove (cmd_remove),
    .price  (cmd_price),
    .qty    (cmd_qty),
    .head   (bid_head),
    .status (bid_status)
  );

  // Ask chain: lowest price at the head
  plb_chain #(
    .LEVELS     (LEVELS_PER_SIDE),
    .BETTER_HIGH(1'b0)
  ) u_ask_chain (
    .clk    (clk),
    .rst    (rst),
    .cmp_en (in_xfer && (side == SIDE_ASK)),
    .cmp_key(price_ticks),
    .apply  (apply_ask),
    .remove (cmd_remove),
    .price  (cmd_price),
    .qty    (cmd_qty),
    .head   (ask_head),
    .status (ask_status)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // apply always produces one result; drop it once moved out
      if (state == ST_APPLY) begin
        pending <= 1'b1;
      end else if (load_out) begin
        pending <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the command for the apply cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_side   <= side;
      cmd_remove <= in_remove;
      cmd_price  <= price_ticks;
      cmd_qty    <= quantity[QTY_W-1:0];
    end
  end

  // A new price into a full side is discarded
  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      pend_dropped <= !cmd_remove && !side_status.any_match && side_status.full;
    end
  end

  // Output register: heads are already updated when the result moves out
  always_ff @(posedge clk) begin
    if (load_out) begin
      bid_valid      <= bid_head.valid;
      best_bid_price <= bid_head.valid ? bid_head.price : '0;
      best_bid_qty   <= bid_head.valid ? bid_head.qty : '0;
      ask_valid      <= ask_head.valid;
      best_ask_price <= ask_head.valid ? ask_head.price : '0;
      best_ask_qty   <= ask_head.valid ? ask_head.qty : '0;
      dropped        <= pend_dropped;
    end
  end

endmodule

`default_nettype wire

@@ hdl/plb_checker.sv @@
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the price level book
// Watches the top level's ports; bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_checker
  import plb_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                bid_valid,
  input wire logic [PRICE_W-1:0]  best_bid_price,
  input wire logic [QTY_W-1:0]    best_bid_qty,
  input wire logic                ask_valid,
  input wire logic [PRICE_W-1:0]  best_ask_price,
  input wire logic [QTY_W-1:0]    best_ask_qty,
  input wire logic                dropped
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_bid_price) &&
      $stable(best_ask_price) && $stable(dropped))
    else $error("result changed while stalled");

  // Empty bid side reports zeros
  a_bid_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bid_valid |-> best_bid_price == '0 && best_bid_qty == '0)
    else $error("empty bid side reports a level");

  // Empty ask side reports zeros
  a_ask_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ask_valid |-> best_ask_price == '0 && best_ask_qty == '0)
    else $error("empty ask side reports a level");

  // A drop only happens on a full side, so some side is populated
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> bid_valid || ask_valid)
    else $error("drop reported with both sides empty");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind price_level_book_top plb_checker u_plb_checker (.*);

`default_nettype wire

@@ bench/book_quote_checker.sv @@
// ----------------------------------------------------------------------------
// book_quote_checker: top-of-book predictor and result comparator
// Watches the update and quote channels. Keeps its own bid and ask level
// tables, predicts the quote for each accepted update and compares it with
// the quote that comes out, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module book_quote_checker
  import plb_pkg::*;
#(
  parameter int LEVELS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic                side,
  input  wire logic [PRICE_W-1:0]  price_ticks,
  input  wire logic signed [31:0]  quantity,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic                bid_valid,
  input  wire logic [PRICE_W-1:0]  best_bid_price,
  input  wire logic [QTY_W-1:0]    best_bid_qty,
  input  wire logic                ask_valid,
  input  wire logic [PRICE_W-1:0]  best_ask_price,
  input  wire logic [QTY_W-1:0]    best_ask_qty,
  input  wire logic                dropped,
  output int                       fail_count,
  output int                       pending,
  output int                       quotes_checked,
  output int                       drops_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {SIDE_BID = 1'b0, SIDE_ASK = 1'b1} side_e;

  typedef struct packed {
    logic               bid_valid;
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0]   bid_qty;
    logic               ask_valid;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   ask_qty;
    logic               dropped;
  } quote_t;

  logic [PRICE_W-1:0] lvl_price [2][LEVELS];
  logic [QTY_W-1:0]   lvl_qty   [2][LEVELS];
  logic               lvl_live  [2][LEVELS];

  quote_t quote_q[$];
  int     mismatches;
  int     checked;
  int     drops;

  // Apply one update to a side; returns 1 when an insert finds the side full.
  function automatic logic apply_level(side_e s, logic [PRICE_W-1:0] p,
                                       logic signed [31:0] q);
    logic removing;
    int   free_idx;
    removing = (q <= 32'sd0);
    free_idx = -1;
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_live[s][i] && lvl_price[s][i] == p) begin
        if (removing) begin
          lvl_live[s][i] = 1'b0;
        end else begin
          lvl_qty[s][i] = q[QTY_W-1:0];
        end
        return 1'b0;
      end
      if (!lvl_live[s][i] && free_idx < 0) begin
        free_idx = i;
      end
    end
    if (removing || free_idx < 0) begin
      return !removing;
    end
    lvl_live[s][free_idx]  = 1'b1;
    lvl_price[s][free_idx] = p;
    lvl_qty[s][free_idx]   = q[QTY_W-1:0];
    return 1'b0;
  endfunction

  // Best level of a side: highest bid or lowest ask; all zero when empty.
  function automatic void best_level(side_e s, output logic v,
                                     output logic [PRICE_W-1:0] p,
                                     output logic [QTY_W-1:0] q);
    v = 1'b0;
    p = '0;
    q = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_live[s][i] && (!v || (s == SIDE_BID ? lvl_price[s][i] > p
                                                  : lvl_price[s][i] < p))) begin
        v = 1'b1;
        p = lvl_price[s][i];
        q = lvl_qty[s][i];
      end
    end
  endfunction

  function automatic quote_t predict_quote(side_e s, logic [PRICE_W-1:0] p,
                                           logic signed [31:0] q);
    quote_t r;
    r.dropped = apply_level(s, p, q);
    best_level(SIDE_BID, r.bid_valid, r.bid_price, r.bid_qty);
    best_level(SIDE_ASK, r.ask_valid, r.ask_price, r.ask_qty);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("quote %0d: %s expected %h, got %h", checked, name, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    quote_t want;
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        lvl_live[SIDE_BID][i] = 1'b0;
        lvl_live[SIDE_ASK][i] = 1'b0;
      end
      quote_q.delete();
      mismatches = 0;
      checked    = 0;
      drops      = 0;
    end else begin
      // push first so a same-edge quote still pairs with the oldest update
      if (in_valid && in_ready) begin
        quote_q.push_back(predict_quote(side_e'(side), price_ticks, quantity));
      end
      if (out_valid && out_ready) begin
        if (quote_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("quote with no update waiting");
          end
          mismatches++;
        end else begin
          want = quote_q.pop_front();
          check_field("bid_valid", 32'(want.bid_valid), 32'(bid_valid));
          check_field("best_bid_price", want.bid_price, best_bid_price);
          check_field("best_bid_qty", 32'(want.bid_qty), 32'(best_bid_qty));
          check_field("ask_valid", 32'(want.ask_valid), 32'(ask_valid));
          check_field("best_ask_price", want.ask_price, best_ask_price);
          check_field("best_ask_qty", 32'(want.ask_qty), 32'(best_ask_qty));
          check_field("dropped", 32'(want.dropped), 32'(dropped));
          if (want.dropped) begin
            drops++;
          end
          checked++;
        end
      end
    end
    fail_count     <= mismatches;
    pending        <= quote_q.size();
    quotes_checked <= checked;
    drops_seen     <= drops;
  end

endmodule

`default_nettype wire

@@ bench/price_level_book_top_test.sv @@
// ----------------------------------------------------------------------------
// price_level_book_top_test: testbench for the price level book
// Drives level updates in bursts with random gaps, stalls the quote side on
// its own pattern, and lets book_quote_checker predict and compare every
// top-of-book quote. Covers edge prices and sizes, replaces, deletes of
// present and absent levels, full sides and draining back to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_book_top_test
  import plb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOOK_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 750;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;

  // traffic shapes for the random part
  typedef enum int {SCN_FILL, SCN_DRAIN, SCN_CHURN} scenario_e;
  // quote-side stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  typedef struct {
    logic               s;
    logic [PRICE_W-1:0] p;
  } level_key_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                side        = 1'b0;
  logic [PRICE_W-1:0]  price_ticks = '0;
  logic signed [31:0]  quantity    = '0;
  logic                out_ready   = 1'b0;
  wire logic           in_ready;
  wire logic           out_valid;
  wire logic           bid_valid;
  wire logic [PRICE_W-1:0] best_bid_price;
  wire logic [QTY_W-1:0]   best_bid_qty;
  wire logic           ask_valid;
  wire logic [PRICE_W-1:0] best_ask_price;
  wire logic [QTY_W-1:0]   best_ask_qty;
  wire logic           dropped;

  int fail_count;
  int pending;
  int quotes_checked;
  int drops_seen;

  int         cycles     = 0;
  int         burst_left = 0;
  int         sent       = 0;
  level_key_t key_pool[$];

  rx_mode_e   rx_mode    = RX_OPEN;
  int         rx_left    = 0;

  price_level_book_top #(
    .LEVELS_PER_SIDE(BOOK_DEPTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .side           (side),
    .price_ticks    (price_ticks),
    .quantity       (quantity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bid_valid      (bid_valid),
    .best_bid_price (best_bid_price),
    .best_bid_qty   (best_bid_qty),
    .ask_valid      (ask_valid),
    .best_ask_price (best_ask_price),
    .best_ask_qty   (best_ask_qty),
    .dropped        (dropped)
  );

  book_quote_checker #(
    .LEVELS(BOOK_DEPTH)
  ) quote_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .side           (side),
    .price_ticks    (price_ticks),
    .quantity       (quantity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .bid_valid      (bid_valid),
    .best_bid_price (best_bid_price),
    .best_bid_qty   (best_bid_qty),
    .ask_valid      (ask_valid),
    .best_ask_price (best_ask_price),
    .best_ask_qty   (best_ask_qty),
    .dropped        (dropped),
    .fail_count     (fail_count),
    .pending        (pending),
    .quotes_checked (quotes_checked),
    .drops_seen     (drops_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run; the limit covers every update waiting out the longest
  // sender gap and quote stall several times over.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Quote-side backpressure: switch pattern when the rx_left countdown ends, so some
  // stretches accept every quote and others hold the pipeline up hard.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(RX_OPEN, RX_TOGGLE));
      rx_left <= $urandom_range(16, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ~out_ready;
    endcase
  end

  // Positive size: mostly random, with the smallest and largest mixed in.
  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return 32'd1;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  // Size that removes a level: zero, the most negative value, or any negative.
  function automatic logic [31:0] rand_cancel();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      default: return 32'h8000_0000 | $urandom();
    endcase
  endfunction

  // Present one update and hold it until transfer. Called at a clock edge;
  // valid is lowered only when a gap actually opens, so a back-to-back
  // transfer keeps it high with a single assignment per edge.
  task automatic send_update(input logic s, input logic [PRICE_W-1:0] p,
                             input logic [31:0] q);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    side        <= s;
    price_ticks <= p;
    quantity    <= q;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and hold until every quote is back.
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    scenario_e          scn;
    logic               s;
    logic [PRICE_W-1:0] base;
    int                 stride;
    int                 pick;
    level_key_t         key;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run on both sides: delete of an absent level, price
    // and size extremes, replace of a present level, deletes by zero and by
    // negative sizes, emptying the side, and one mid-range insert.
    for (int d = 0; d < 2; d++) begin
      s = d[0];
      send_update(s, 32'd5, 32'd0);
      send_update(s, 32'd0, 32'd1);
      send_update(s, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_update(s, 32'd0, 32'd100);
      send_update(s, 32'h8000_0000, 32'h8000_0000);
      send_update(s, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_update(s, 32'd0, 32'd0);
      send_update(s, 32'h5555_AAAA, 32'h2AAA_5555);
    end

    // Random part: fill a side past capacity, drain everything known, or
    // churn with replaces, deletes, new levels and raw noise. Start with a
    // fill so a full side shows up early.
    sent = 0;
    scn  = SCN_FILL;
    while (sent < RANDOM_ITEMS) begin
      case (scn)
        SCN_FILL: begin
          s      = 1'($urandom_range(0, 1));
          base   = $urandom();
          stride = $urandom_range(1, 3);
          for (int k = 0; k < BOOK_DEPTH + 4; k++) begin
            key.s = s;
            key.p = base + k * stride;
            key_pool.push_back(key);
            send_update(key.s, key.p, rand_size());
          end
        end
        SCN_DRAIN: begin
          // let the pipeline empty before the book is torn down
          wait_drained();
          while (key_pool.size() != 0) begin
            pick = $urandom_range(0, key_pool.size() - 1);
            key  = key_pool[pick];
            key_pool.delete(pick);
            send_update(key.s, key.p, rand_cancel());
          end
        end
        default: begin
          repeat (40) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 && key_pool.size() != 0) begin
              key = key_pool[$urandom_range(0, key_pool.size() - 1)];
              send_update(key.s, key.p,
                          ($urandom_range(0, 1) == 1) ? rand_size() : rand_cancel());
            end else if (pick < 8) begin
              key.s = 1'($urandom_range(0, 1));
              key.p = $urandom();
              key_pool.push_back(key);
              send_update(key.s, key.p, rand_size());
            end else begin
              send_update(1'($urandom_range(0, 1)), $urandom(), $urandom());
            end
          end
        end
      endcase
      pick = $urandom_range(0, 9);
      scn  = (pick < 2) ? SCN_FILL : (pick < 4) ? SCN_DRAIN : SCN_CHURN;
    end

    // Wait out the remaining quotes, then SETTLE_CYCLES more for strays.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d random updates after the directed set", sent);
    $display("%0d quotes checked, %0d inserts dropped on a full side",
             quotes_checked, drops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ price_level_book_top.f @@
hdl/plb_pkg.sv
hdl/plb_cell.sv
hdl/plb_chain.sv
hdl/price_level_book_top.sv
hdl/plb_checker.sv
bench/book_quote_checker.sv
bench/price_level_book_top_test.sv
